// ===== design/mset_pkg.sv =====
// ----------------------------------------------------------------------------
// mset_pkg: shared types and constants of the event timer scheduler
// Field widths, command and event codes, and the structs that travel
// between the controller and the row of timer cells.
// ----------------------------------------------------------------------------
package mset_pkg;

  localparam int SLOTS      = 4;   // number of timer cells in the row
  localparam int SLOT_W     = 2;   // slot field width
  localparam int KIND_W     = 2;   // command kind width
  localparam int SPAN_W     = 31;  // duration, budget, amount, slice, period
  localparam int NOW_W      = 32;  // running time
  localparam int EXP_W      = 40;  // expiry, two's complement
  localparam int TAG_W      = 24;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 64;
  localparam int ADDR_W     = 3;

  localparam logic [SPAN_W-1:0] WRAP_RESET = 31'd1024000000;  // one second

  // command kinds on the input tuser
  localparam logic [KIND_W-1:0] KIND_ARM     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SCAN    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;

  // result kinds on the output tuser
  localparam logic EV_FIRED = 1'b0;
  localparam logic EV_SLICE = 1'b1;

  // register word index (paddr[2])
  localparam logic REG_WRAP = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ADV
  } state_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [SPAN_W-1:0] ticks;
  } tok_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              wrap;
    logic [SPAN_W-1:0] wrap_period;
    logic [SPAN_W-1:0] duration;
    logic [TAG_W-1:0]  tag;
  } cmd_t;

  // fired report from one cell
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } fire_t;

endpackage

// ===== design/mset_cell.sv =====
// ----------------------------------------------------------------------------
// mset_cell: one timer slot
// Holds expiry, enable and tag; checks the scan token as it passes,
// fires when due and narrows the slice carried to the next cell.
// ----------------------------------------------------------------------------
module mset_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic                       arm,
  input  logic [mset_pkg::NOW_W-1:0] now,
  input  mset_pkg::cmd_t             cmd,
  input  mset_pkg::tok_t             tok_in,
  output mset_pkg::tok_t             tok_out,
  output mset_pkg::fire_t            fire
);

  logic                       enabled;
  logic [mset_pkg::EXP_W-1:0] expiry;
  logic [mset_pkg::TAG_W-1:0] tag;
  mset_pkg::tok_t             tok;

  logic [mset_pkg::EXP_W:0]   ahead;
  logic [mset_pkg::EXP_W:0]   wrapped;
  logic [mset_pkg::EXP_W-1:0] expiry_wrapped;
  logic [mset_pkg::EXP_W-1:0] expiry_armed;
  logic                       due;
  logic                       closer;

  // distance to expiry, 41-bit signed
  assign ahead = {expiry[mset_pkg::EXP_W-1], expiry}
               - {{(mset_pkg::EXP_W+1-mset_pkg::NOW_W){1'b0}}, now};

  assign due = tok.valid && enabled && (ahead[mset_pkg::EXP_W] || (ahead == '0));

  assign closer = tok.valid && enabled && !due
               && (ahead[mset_pkg::EXP_W:mset_pkg::SPAN_W] == '0)
               && (ahead[mset_pkg::SPAN_W-1:0] < tok.ticks);

  always_comb begin
    tok_out.valid = tok.valid;
    tok_out.ticks = closer ? ahead[mset_pkg::SPAN_W-1:0] : tok.ticks;
    fire.valid    = due;
    fire.tag      = tag;
  end

  // wrap: subtract the period, saturate at -2^39
  assign wrapped = {expiry[mset_pkg::EXP_W-1], expiry}
                 - {{(mset_pkg::EXP_W+1-mset_pkg::SPAN_W){1'b0}}, cmd.wrap_period};
  assign expiry_wrapped = (wrapped[mset_pkg::EXP_W] && !wrapped[mset_pkg::EXP_W-1])
                        ? {1'b1, {(mset_pkg::EXP_W-1){1'b0}}}
                        : wrapped[mset_pkg::EXP_W-1:0];

  assign expiry_armed = {{(mset_pkg::EXP_W-mset_pkg::NOW_W){1'b0}}, now}
                      + {{(mset_pkg::EXP_W-mset_pkg::SPAN_W){1'b0}}, cmd.duration};

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      tok     <= '0;
    end else begin
      if (step) begin
        tok <= tok_in;
      end
      if (arm) begin
        enabled <= 1'b1;
      end else if (due && step) begin
        enabled <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (arm) begin
      expiry <= expiry_armed;
      tag    <= cmd.tag;
    end else if (cmd.wrap && enabled) begin
      expiry <= expiry_wrapped;
    end
  end

endmodule

// ===== design/multi_slot_event_timer_scheduler.sv =====
// ----------------------------------------------------------------------------
// multi_slot_event_timer_scheduler: one-shot timer slots with a running time
// Arm, scan and advance commands over a stream port; fired slots and the
// next slice come back as a result stream. Wrap period on an APB port.
// ----------------------------------------------------------------------------
// Arm: the slot registers load on the transfer. Advance: sum, then wrap compare and subtract.
// Scan: the token walks the row of SLOTS cells, one cell a cycle while the
//   result port is not stalled; a fired slot leaves as it is passed, and the
//   slice report follows once the token has left the last cell.
// A waiting result holds the whole row. One command at a time.
// Reset (rst, synchronous): time 0, all slots disabled, period one second.
module multi_slot_event_timer_scheduler (
  input  logic                            clk,
  input  logic                            rst,
  // command stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // slot[1:0], duration[32:2], tag[56:33], budget[87:57], amount[118:88]
  input  logic [mset_pkg::IN_DATA_W-1:0]  s_tdata,
  // kind[1:0]
  input  logic [mset_pkg::KIND_W-1:0]     s_tuser,
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // fired_slot[1:0], fired_tag[25:2], next_slice[56:26]
  output logic [mset_pkg::OUT_DATA_W-1:0] m_tdata,
  // event_kind[0]
  output logic                            m_tuser,
  output logic                            m_tlast,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mset_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  mset_pkg::state_t state, state_next;

  logic [mset_pkg::SPAN_W-1:0] wrap_period;
  logic [mset_pkg::NOW_W-1:0]  now_time;
  logic [mset_pkg::NOW_W:0]    adv_sum;     // now + amount, one spare bit
  mset_pkg::tok_t              tail_tok;    // token after the last cell

  // input fields
  logic [mset_pkg::SLOT_W-1:0] in_slot;
  logic [mset_pkg::SPAN_W-1:0] in_duration;
  logic [mset_pkg::TAG_W-1:0]  in_tag;
  logic [mset_pkg::SPAN_W-1:0] in_budget;
  logic [mset_pkg::SPAN_W-1:0] in_amount;

  assign in_slot     = s_tdata[1:0];
  assign in_duration = s_tdata[32:2];
  assign in_tag      = s_tdata[56:33];
  assign in_budget   = s_tdata[87:57];
  assign in_amount   = s_tdata[118:88];

  // the row moves only when the result register can take a value
  logic step;
  logic cmd_xfer, arm_go, scan_go, adv_go;

  assign step     = !m_tvalid || m_tready;
  assign cmd_xfer = s_tvalid && s_tready;
  assign arm_go   = cmd_xfer && (s_tuser == mset_pkg::KIND_ARM);
  assign scan_go  = cmd_xfer && (s_tuser == mset_pkg::KIND_SCAN);
  assign adv_go   = cmd_xfer && (s_tuser == mset_pkg::KIND_ADVANCE);

  // ---- state machine ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mset_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      mset_pkg::ST_IDLE: begin
        s_tready = step;
        if (scan_go) begin
          state_next = mset_pkg::ST_SCAN;
        end else if (adv_go) begin
          state_next = mset_pkg::ST_ADV;
        end
      end
      mset_pkg::ST_SCAN: begin
        if (step && tail_tok.valid) begin
          state_next = mset_pkg::ST_IDLE;
        end
      end
      mset_pkg::ST_ADV: begin
        state_next = mset_pkg::ST_IDLE;
      end
      default: begin
        state_next = mset_pkg::ST_IDLE;
      end
    endcase
  end

  // ---- running time and wrap ----
  logic [mset_pkg::NOW_W:0]   wrap_ext;
  logic                       wrap_hit;
  logic [mset_pkg::NOW_W:0]   adv_rem;
  logic [mset_pkg::NOW_W-1:0] now_next;

  assign wrap_ext = {{(mset_pkg::NOW_W+1-mset_pkg::SPAN_W){1'b0}}, wrap_period};
  assign wrap_hit = (state == mset_pkg::ST_ADV) && (adv_sum >= wrap_ext);
  assign adv_rem  = wrap_hit ? (adv_sum - wrap_ext) : adv_sum;
  // saturate at all ones when a single subtraction is not enough
  assign now_next = adv_rem[mset_pkg::NOW_W] ? '1 : adv_rem[mset_pkg::NOW_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      now_time <= '0;
    end else if (state == mset_pkg::ST_ADV) begin
      now_time <= now_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_go) begin
      adv_sum <= {1'b0, now_time}
               + {{(mset_pkg::NOW_W+1-mset_pkg::SPAN_W){1'b0}}, in_amount};
    end
  end

  // ---- configuration ----
  logic cfg_write;
  assign cfg_write = psel && penable && pwrite && pready
                  && (paddr[mset_pkg::ADDR_W-1] == mset_pkg::REG_WRAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_period <= mset_pkg::WRAP_RESET;
    end else if (cfg_write) begin
      wrap_period <= pwdata[mset_pkg::SPAN_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[mset_pkg::ADDR_W-1] == mset_pkg::REG_WRAP)
                ? {{(32-mset_pkg::SPAN_W){1'b0}}, wrap_period} : '0;

  // ---- row of cells ----
  mset_pkg::cmd_t  cmd;
  mset_pkg::tok_t  tok_link [mset_pkg::SLOTS+1];
  mset_pkg::fire_t fire     [mset_pkg::SLOTS];
  logic            arm_sel  [mset_pkg::SLOTS];

  always_comb begin
    cmd.wrap        = wrap_hit;
    cmd.wrap_period = wrap_period;
    cmd.duration    = in_duration;
    cmd.tag         = in_tag;
    // scan token enters cell 0 carrying the budget
    tok_link[0].valid = scan_go;
    tok_link[0].ticks = in_budget;
    for (int i = 0; i < mset_pkg::SLOTS; i++) begin
      arm_sel[i] = arm_go && (int'(in_slot) == i);
    end
  end

  for (genvar g = 0; g < mset_pkg::SLOTS; g++) begin : g_cell
    mset_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .step    (step),
      .arm     (arm_sel[g]),
      .now     (now_time),
      .cmd     (cmd),
      .tok_in  (tok_link[g]),
      .tok_out (tok_link[g+1]),
      .fire    (fire[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_tok <= '0;
    end else if (step) begin
      tail_tok <= tok_link[mset_pkg::SLOTS];
    end
  end

  // only the cell holding the token can fire
  logic                        fire_any;
  logic [mset_pkg::SLOT_W-1:0] fired_idx;
  logic [mset_pkg::TAG_W-1:0]  fired_tag;

  always_comb begin
    fire_any  = 1'b0;
    fired_idx = '0;
    fired_tag = '0;
    for (int i = 0; i < mset_pkg::SLOTS; i++) begin
      if (fire[i].valid) begin
        fire_any  = 1'b1;
        fired_idx = mset_pkg::SLOT_W'(i);
        fired_tag = fire[i].tag;
      end
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= fire_any || ((state == mset_pkg::ST_SCAN) && tail_tok.valid);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (fire_any) begin
        m_tuser <= mset_pkg::EV_FIRED;
        m_tlast <= 1'b0;
        m_tdata <= {{(mset_pkg::OUT_DATA_W-mset_pkg::SPAN_W-mset_pkg::TAG_W
                     -mset_pkg::SLOT_W){1'b0}},
                    {mset_pkg::SPAN_W{1'b0}}, fired_tag, fired_idx};
      end else begin
        m_tuser <= mset_pkg::EV_SLICE;
        m_tlast <= 1'b1;
        m_tdata <= {{(mset_pkg::OUT_DATA_W-mset_pkg::SPAN_W-mset_pkg::TAG_W
                     -mset_pkg::SLOT_W){1'b0}},
                    tail_tok.ticks, {mset_pkg::TAG_W{1'b0}}, {mset_pkg::SLOT_W{1'b0}}};
      end
    end
  end

endmodule

// ===== design/mset_checker.sv =====
// ----------------------------------------------------------------------------
// mset_checker: port-level checks of the event timer scheduler
// Watches the command handshake and the result port; bound to the top level.
// ----------------------------------------------------------------------------
module mset_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mset_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser,
  input logic                            m_tlast
);

  // the slice report closes a scan, and only it
  a_last_is_slice: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == mset_pkg::EV_SLICE)))
    else $error("tlast does not match the slice report");

  // a fired event carries no slice
  a_fired_no_slice: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == mset_pkg::EV_FIRED)) |-> (m_tdata[56:26] == '0))
    else $error("fired event with non-zero slice");

  // a command is taken only when the result side can move
  a_take_when_free: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tready))
    else $error("command taken while a result is stuck");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind multi_slot_event_timer_scheduler mset_checker u_mset_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
